// ===== src/pbls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbls_pkg
// Shared types and constants for the front-panel button/LED scanner.
// ----------------------------------------------------------------------------
package pbls_pkg;

  localparam int unsigned LedW      = 24;
  localparam int unsigned BtnW      = 8;
  localparam int unsigned TickW     = 9;
  localparam int unsigned BlinkCntW = 16;
  localparam int unsigned OriginW   = 8;

  localparam logic [LedW-1:0]    LedResetImage = LedW'(32'h0040_0000);
  localparam logic [TickW-1:0]   MenuHalf      = 9'h100;
  localparam logic [OriginW-1:0] BlinkHalf     = 8'h80;

  typedef enum logic [1:0] {
    REQ_TICK      = 2'd0,
    REQ_LED_SET   = 2'd1,
    REQ_BLINK     = 2'd2,
    REQ_RETRIGGER = 2'd3
  } req_e;

  typedef enum logic {
    CFG_MENU_EN   = 1'b0,
    CFG_MENU_MASK = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ON   = 3'b010,
    PH_OFF  = 3'b100
  } rtg_phase_e;

  typedef struct packed {
    req_e                 req_type;
    logic [BtnW-1:0]      button_bits;
    logic [LedW-1:0]      led_mask;
    logic                 led_value;
    logic [BlinkCntW-1:0] blink_count;
  } in_item_t;

  typedef struct packed {
    logic [LedW-1:0] led_drive;
    logic            button_event;
    logic [BtnW-1:0] button_changed;
    logic [BtnW-1:0] button_state;
    logic            gate_on;
  } out_item_t;

  // per-transaction control handed from the input stage to the state units
  typedef struct packed {
    logic fire;
    req_e req;
  } step_t;

endpackage

// ===== src/pbls_buttons.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbls_buttons
// Two-tick button debounce; latches the whole byte on a confirmed change.
// ----------------------------------------------------------------------------
module pbls_buttons (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pbls_pkg::step_t       step_i,
  input  logic [pbls_pkg::BtnW-1:0] buttons_i,
  output logic                  event_o,
  output logic [pbls_pkg::BtnW-1:0] changed_o,
  output logic [pbls_pkg::BtnW-1:0] state_o
);
  import pbls_pkg::*;

  logic [BtnW-1:0] stable_q, stable_d;
  logic [BtnW-1:0] pending_q, pending_d;
  logic [BtnW-1:0] diff;
  logic            is_tick;

  always_comb begin
    is_tick   = (step_i.req == REQ_TICK);
    diff      = buttons_i ^ stable_q;
    changed_o = is_tick ? (diff & pending_q) : '0;
    pending_d = is_tick ? diff : pending_q;
    event_o   = (changed_o != '0);
    stable_d  = event_o ? buttons_i : stable_q;
    state_o   = stable_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q  <= '0;
      pending_q <= '0;
    end else if (step_i.fire) begin
      stable_q  <= stable_d;
      pending_q <= pending_d;
    end
  end

endmodule

// ===== src/pbls_leds.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbls_leds
// LED image, blink overlay, menu square wave and tick counter.
// ----------------------------------------------------------------------------
module pbls_leds (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pbls_pkg::step_t               step_i,
  input  logic [pbls_pkg::LedW-1:0]     mask_i,
  input  logic                          value_i,
  input  logic [pbls_pkg::BlinkCntW-1:0] count_i,
  input  logic                          menu_en_i,
  input  logic [pbls_pkg::LedW-1:0]     menu_mask_i,
  output logic [pbls_pkg::LedW-1:0]     drive_o
);
  import pbls_pkg::*;

  logic [LedW-1:0]      image_q, image_d;
  logic [LedW-1:0]      bits_q, bits_d;
  logic [BlinkCntW-1:0] left_q, left_d, left_nx;
  logic [OriginW-1:0]   origin_q, origin_d;
  logic [TickW-1:0]     tick_q, tick_d;
  logic [OriginW-1:0]   phase;
  logic [LedW-1:0]      drive;
  logic                 active;

  always_comb begin
    image_d  = image_q;
    bits_d   = bits_q;
    left_d   = left_q;
    origin_d = origin_q;
    tick_d   = tick_q;
    case (step_i.req)
      REQ_TICK:    tick_d = tick_q + TickW'(1);
      REQ_LED_SET: image_d = value_i ? (image_q | mask_i) : (image_q & ~mask_i);
      REQ_BLINK: begin
        origin_d = tick_q[OriginW-1:0];
        bits_d   = mask_i;
        left_d   = (mask_i != '0) ? count_i : '0;
      end
      default: ;
    endcase

    active  = (left_d != '0);
    phase   = tick_d[OriginW-1:0] - origin_d;
    left_nx = left_d;
    if (active && step_i.req == REQ_TICK && tick_d[OriginW-1:0] == origin_d) begin
      left_nx = left_d - BlinkCntW'(1);
    end

    drive = ~image_d;
    if (active && phase > BlinkHalf) begin
      drive = ~(image_d ^ bits_d);
    end
    if (menu_en_i) begin
      if (tick_d > MenuHalf) drive = drive | menu_mask_i;
      else                   drive = drive & ~menu_mask_i;
    end
    drive_o = drive;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_q  <= LedResetImage;
      bits_q   <= '0;
      left_q   <= '0;
      origin_q <= '0;
      tick_q   <= '0;
    end else if (step_i.fire) begin
      image_q  <= image_d;
      bits_q   <= bits_d;
      left_q   <= left_nx;
      origin_q <= origin_d;
      tick_q   <= tick_d;
    end
  end

endmodule

// ===== src/pbls_gate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbls_gate
// Gate retrigger: off for one tick, then back on.
// ----------------------------------------------------------------------------
module pbls_gate (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pbls_pkg::step_t step_i,
  output logic            gate_o
);
  import pbls_pkg::*;

  rtg_phase_e phase_q, phase_d;
  logic       gate_q, gate_d;

  always_comb begin
    phase_d = phase_q;
    gate_d  = gate_q;
    if (step_i.req == REQ_RETRIGGER) begin
      phase_d = PH_OFF;
    end else if (step_i.req == REQ_TICK) begin
      if (phase_q == PH_OFF) begin
        phase_d = PH_ON;
        gate_d  = 1'b0;
      end else if (phase_q != PH_IDLE) begin
        phase_d = PH_IDLE;
        gate_d  = 1'b1;
      end
    end
    gate_o = gate_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      gate_q  <= 1'b0;
    end else if (step_i.fire) begin
      phase_q <= phase_d;
      gate_q  <= gate_d;
    end
  end

endmodule

// ===== src/panel_button_led_scanner_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// panel_button_led_scanner_top
// Front-panel scanner: button debounce, LED drive image, gate retrigger.
// ----------------------------------------------------------------------------
// Pipeline: an input transaction passes the input reg, then the result reg.
// Throughput: one transaction per cycle unless the output stalls; the state update is a single pass.
// Reset: async active low; LED image 0x400000, gate phase idle, other control state and config 0.
// Config port is always ready; writes take effect on the next transaction.
module panel_button_led_scanner_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pbls_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pbls_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  pbls_pkg::cfg_idx_e            cfg_index_i,
  input  logic [pbls_pkg::LedW-1:0]     cfg_data_i
);
  import pbls_pkg::*;

  in_item_t        in_q;
  logic            in_valid_q;
  out_item_t       res_q, res_d;
  logic            res_valid_q;
  logic            res_ready;
  step_t           step;
  logic            menu_en_q;
  logic [LedW-1:0] menu_mask_q;

  assign res_ready   = !res_valid_q || out_ready_i;
  assign in_ready_o  = !in_valid_q || res_ready;
  assign step.fire   = in_valid_q && res_ready;
  assign step.req    = in_q.req_type;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      menu_en_q   <= 1'b0;
      menu_mask_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MENU_EN:   menu_en_q   <= cfg_data_i[0];
        CFG_MENU_MASK: menu_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (res_ready)  res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (step.fire)                res_q <= res_d;
  end

  pbls_buttons u_buttons (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .buttons_i (in_q.button_bits),
    .event_o   (res_d.button_event),
    .changed_o (res_d.button_changed),
    .state_o   (res_d.button_state)
  );

  pbls_leds u_leds (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .mask_i      (in_q.led_mask),
    .value_i     (in_q.led_value),
    .count_i     (in_q.blink_count),
    .menu_en_i   (menu_en_q),
    .menu_mask_i (menu_mask_q),
    .drive_o     (res_d.led_drive)
  );

  pbls_gate u_gate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .gate_o (res_d.gate_on)
  );

  a_ready_low_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && res_valid_q))
    else $error("input stalled while a pipeline stage is empty");

  a_fire_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.fire |=> res_valid_q)
    else $error("processed transaction did not reach the result register");

  a_event_has_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.button_event) |-> (res_q.button_changed != '0))
    else $error("button event without changed bits");

  a_no_event_off_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step.fire && step.req != REQ_TICK) |=> !res_q.button_event)
    else $error("button event on a non-tick transaction");

endmodule
